@@ sv/u8sd_pkg.sv @@
// package: shared types, constants and the lead-byte classifier for the utf-8 decoder
`timescale 1ns / 1ps
package u8sd_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [20:0] CP_MIN_2      = 21'h000080;
   localparam logic [20:0] CP_MIN_3      = 21'h000800;
   localparam logic [20:0] CP_MIN_4      = 21'h010000;
   localparam logic [20:0] CP_END_4      = 21'h110000;
   localparam logic [20:0] CP_ESC_BASE   = 21'h00EE00;
   localparam logic [20:0] CP_ESC_LAST   = 21'h00EEFF;

   localparam logic [7:0] LEAD_ASCII_END = 8'h80;
   localparam logic [7:0] LEAD_2_START   = 8'hC2;
   localparam logic [7:0] LEAD_3_START   = 8'hE0;
   localparam logic [7:0] LEAD_4_START   = 8'hF0;
   localparam logic [7:0] LEAD_4_END     = 8'hF8;

   localparam logic [2:0] SEQ_BAD = 3'd0;
   localparam logic [2:0] SEQ_1   = 3'd1;
   localparam logic [2:0] SEQ_2   = 3'd2;
   localparam logic [2:0] SEQ_3   = 3'd3;
   localparam logic [2:0] SEQ_4   = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        decode_error;
      logic [2:0]  bytes_used;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
      logic [2:0] seq_len;
   } q_item_type;

   function automatic logic [2:0] seq_length(input logic [7:0] lead);
      logic [2:0] len;
      if (lead < LEAD_ASCII_END) len = SEQ_1;
      else if (lead < LEAD_2_START) len = SEQ_BAD;
      else if (lead < LEAD_3_START) len = SEQ_2;
      else if (lead < LEAD_4_START) len = SEQ_3;
      else if (lead < LEAD_4_END) len = SEQ_4;
      else len = SEQ_BAD;
      return len;
   endfunction

endpackage

@@ sv/utf8_stream_decoder_core.sv @@
// top level: utf-8 byte stream decoder with error escapes
//
//   channel  direction  ports                               payload
//   req      in         req_valid, req_ready, req_data      data_byte, end_of_buffer
//   rsp      out        rsp_valid, rsp_ready, rsp_data      code_point, decode_error,
//                                                           bytes_used, last_of_run
//
// the back end loads each byte into its window, then gives the results that it allows
// before it takes the next byte; a request that only waits for more bytes gives none
// a two-entry queue lets the front take requests while the back end works
// reset is synchronous and clears the queue, the pending byte count and rsp_valid
// with rsp_ready low the result register holds and the back end stops; the front
// keeps taking requests until the queue is full
`timescale 1ns / 1ps
module utf8_stream_decoder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  u8sd_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output u8sd_pkg::rsp_type  rsp_data
);

   logic                  q_valid;
   logic                  q_ready;
   u8sd_pkg::q_item_type  q_item;

   u8sd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item)
   );

   u8sd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sv/u8sd_front.sv @@
// front end: accepts request bytes, classifies the lead length and queues them
`timescale 1ns / 1ps
module u8sd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  u8sd_pkg::req_type     req_data,
   output logic                  q_valid,
   input  logic                  q_ready,
   output u8sd_pkg::q_item_type  q_item
);

   u8sd_pkg::q_item_type           q_mem [u8sd_pkg::QUEUE_DEPTH];
   logic [u8sd_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [u8sd_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [u8sd_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                           push, pop;
   u8sd_pkg::q_item_type           new_item;

   assign req_ready = (count_ff < u8sd_pkg::QCNT_W'(u8sd_pkg::QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = q_mem[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      new_item.data_byte     = req_data.data_byte;
      new_item.end_of_buffer = req_data.end_of_buffer;
      new_item.seq_len       = u8sd_pkg::seq_length(req_data.data_byte);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == u8sd_pkg::QPTR_W'(u8sd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == u8sd_pkg::QPTR_W'(u8sd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= new_item;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= u8sd_pkg::QCNT_W'(u8sd_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

@@ sv/u8sd_back.sv @@
// back end: pending byte window, sequence check and registered result stage
`timescale 1ns / 1ps
module u8sd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  u8sd_pkg::q_item_type  q_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output u8sd_pkg::rsp_type     rsp_data
);

   logic [7:0]            byte_ff [4];
   logic [7:0]            byte_in [4];
   logic [2:0]            len_ff  [4];
   logic [2:0]            len_in  [4];
   logic [2:0]            cnt_ff, cnt_in;
   logic                  eob_ff, eob_in;
   logic                  busy_ff, busy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   u8sd_pkg::rsp_type     rsp_ff, rsp_in;

   logic                  pop;
   logic [2:0]            lead_len;
   logic                  brk, ok, cont1, cont2, cont3;
   logic [20:0]           v2, v3, v4, cp;
   logic                  ok2, ok3, ok4;
   logic [2:0]            used, rem, next_len;
   logic                  last, fire;
   logic [2:0]            src;

   assign q_ready   = !busy_ff;
   assign pop       = q_valid && !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      lead_len = len_ff[0];
      cont1    = (byte_ff[1][7:6] == 2'b10);
      cont2    = (byte_ff[2][7:6] == 2'b10);
      cont3    = (byte_ff[3][7:6] == 2'b10);
      v2 = {10'd0, byte_ff[0][4:0], byte_ff[1][5:0]};
      v3 = {5'd0, byte_ff[0][3:0], byte_ff[1][5:0], byte_ff[2][5:0]};
      v4 = {byte_ff[0][2:0], byte_ff[1][5:0], byte_ff[2][5:0], byte_ff[3][5:0]};
      ok2 = cont1 && (v2 >= u8sd_pkg::CP_MIN_2);
      // 3-byte results in the escape window are refused
      ok3 = cont1 && cont2 && (v3 >= u8sd_pkg::CP_MIN_3) &&
            !((v3 >= u8sd_pkg::CP_ESC_BASE) && (v3 <= u8sd_pkg::CP_ESC_LAST));
      ok4 = cont1 && cont2 && cont3 && (v4 >= u8sd_pkg::CP_MIN_4) &&
            (v4 < u8sd_pkg::CP_END_4);

      // wait for more bytes unless the buffer is ending
      brk = (lead_len > u8sd_pkg::SEQ_1) && (cnt_ff < lead_len) && !eob_ff;

      ok = 1'b0;
      cp = u8sd_pkg::CP_ESC_BASE + {13'd0, byte_ff[0]};
      if (cnt_ff >= lead_len) begin
         case (lead_len)
            u8sd_pkg::SEQ_2: begin
               ok = ok2;
               cp = ok2 ? v2 : cp;
            end
            u8sd_pkg::SEQ_3: begin
               ok = ok3;
               cp = ok3 ? v3 : cp;
            end
            u8sd_pkg::SEQ_4: begin
               ok = ok4;
               cp = ok4 ? v4 : cp;
            end
            default: begin
               ok = 1'b0;
            end
         endcase
      end
      if (lead_len == u8sd_pkg::SEQ_1) begin
         cp = {13'd0, byte_ff[0]};
      end

      used     = ok ? lead_len : 3'd1;
      rem      = cnt_ff - used;
      next_len = len_ff[used[1:0]];
      // last result when nothing is left or the next lead must wait
      last = (rem == 3'd0) ||
             (!eob_ff && (next_len > u8sd_pkg::SEQ_1) && (rem < next_len));
      fire = busy_ff && !brk && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      byte_in      = byte_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      eob_in       = eob_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      src          = 3'd0;

      if (pop) begin
         byte_in[cnt_ff[1:0]] = q_item.data_byte;
         len_in[cnt_ff[1:0]]  = q_item.seq_len;
         cnt_in               = cnt_ff + 3'd1;
         eob_in               = q_item.end_of_buffer;
         busy_in              = 1'b1;
      end else if (busy_ff && brk) begin
         busy_in = 1'b0;
      end else if (fire) begin
         for (int i = 0; i < 4; i++) begin
            src = 3'(i) + used;
            if (src < 3'd4) begin
               byte_in[i] = byte_ff[src[1:0]];
               len_in[i]  = len_ff[src[1:0]];
            end
         end
         cnt_in                = rem;
         busy_in               = !last;
         rsp_valid_in          = 1'b1;
         rsp_in.code_point     = cp;
         rsp_in.decode_error   = (lead_len != u8sd_pkg::SEQ_1) && !ok;
         rsp_in.bytes_used     = used;
         rsp_in.last_of_run    = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      len_ff  <= len_in;
      eob_ff  <= eob_in;
      rsp_ff  <= rsp_in;
   end

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != 3'd0) && (cnt_ff <= 3'd4))
      else $error("working with an empty or overfull byte window");

   a_idle_room: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff <= 3'd3)
      else $error("no room for the next byte while idle");

   a_eob_drains: assert property (@(posedge clock) disable iff (reset)
      (fire && last && eob_ff) |=> (cnt_ff == 3'd0))
      else $error("bytes left pending after end of buffer");

endmodule
